// ===== hdl/ttmr_pkg.sv =====
// Package for the two-trade maximum rise block.
// Holds the default sizes and the control struct passed from the sequencer to the scan datapath.
// No dependencies.
`default_nettype none

package ttmr_pkg;

  localparam int TTMR_MAX_DAYS   = 1024;
  localparam int TTMR_PRICE_BITS = 16;

  // Per-cycle control from the sequencer to the backward scan.
  typedef struct packed {
    logic clear;      // start of a new backward pass
    logic data_vld;   // read data from the day store is valid this cycle
    logic data_last;  // this is the earliest day, the final one of the pass
  } ttmr_scan_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/two_trade_max_rise.sv =====
// Two-trade maximum rise: best combined gain of at most two buy-then-sell trades.
// Loading takes one price beat per cycle; busy stays low until the beat marked last.
// After that beat the backward pass reads one stored day per cycle from the day store
// port, and the result strobe follows the last read through the store and scan registers.
// The result is shown for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer and counters; the store is not cleared.
`default_nettype none

module two_trade_max_rise #(
  parameter int MAX_DAYS   = ttmr_pkg::TTMR_MAX_DAYS,
  parameter int PRICE_BITS = ttmr_pkg::TTMR_PRICE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [PRICE_BITS-1:0] in_price,
  input  wire logic                  in_last_day,
  output logic                       out_valid,
  output logic      [PRICE_BITS:0]   out_best_total,
  output logic                       out_dropped
);

  import ttmr_pkg::*;

  localparam int AW = $clog2(MAX_DAYS);
  localparam int CW = $clog2(MAX_DAYS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_DAYS);
  localparam logic [AW-1:0] LAST_INDEX = AW'(MAX_DAYS - 1);

  typedef enum logic {
    ST_LOAD,
    ST_SCAN
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         count_r;
  logic [PRICE_BITS-1:0] low_r;
  logic [PRICE_BITS-1:0] best_r;
  logic                  overflow_r;
  logic [AW-1:0]         ptr_r;
  logic                  iss_r;
  logic                  data_vld_r;
  logic                  data_last_r;

  logic                  accept;
  logic                  has_room;
  logic [PRICE_BITS-1:0] low_nxt;
  logic [PRICE_BITS-1:0] best_nxt;
  logic [PRICE_BITS-1:0] rise;
  logic [2*PRICE_BITS-1:0] rd_data;
  logic                  scan_done;
  ttmr_scan_ctrl_t       scan_ctrl;

  assign busy     = (state_r != ST_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count_r < FULL_COUNT);
  assign rise     = in_price - low_r;

  // Forward step: running minimum and the best single rise up to this day.
  always_comb begin
    low_nxt  = low_r;
    best_nxt = best_r;
    if (count_r == '0) begin
      low_nxt  = in_price;
      best_nxt = '0;
    end else if (in_price < low_r) begin
      low_nxt = in_price;
    end else if (rise > best_r) begin
      best_nxt = rise;
    end
  end

  // Loading registers. A last beat closes the sequence and clears them for the next one;
  // the stored days stay in the memory for the backward pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      low_r      <= '0;
      best_r     <= '0;
      overflow_r <= 1'b0;
    end else if (accept) begin
      if (in_last_day) begin
        count_r <= '0;
        low_r   <= '0;
        best_r  <= '0;
      end else if (has_room) begin
        count_r <= count_r + 1'b1;
        low_r   <= low_nxt;
        best_r  <= best_nxt;
      end else begin
        overflow_r <= 1'b1;
      end
    end else if (scan_done) begin
      // The flag is shown with the result, then dropped for the next sequence.
      overflow_r <= 1'b0;
    end
  end

  // Sequencer: loading, then issuing one read a cycle from the newest day down to day 0.
  // The flag of a dropped last beat is folded into out_dropped below, so the sequence
  // stays correct whether or not the closing beat itself fitted in the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      iss_r       <= 1'b0;
      data_vld_r  <= 1'b0;
      data_last_r <= 1'b0;
    end else begin
      data_vld_r  <= iss_r;
      data_last_r <= iss_r && (ptr_r == '0);
      case (state_r)
        ST_LOAD: begin
          if (accept && in_last_day) begin
            state_r <= ST_SCAN;
            iss_r   <= 1'b1;
            if (has_room) begin
              ptr_r <= count_r[AW-1:0];
            end else begin
              ptr_r <= LAST_INDEX;
            end
          end
        end
        ST_SCAN: begin
          if (iss_r) begin
            if (ptr_r == '0) begin
              iss_r <= 1'b0;
            end else begin
              ptr_r <= ptr_r - 1'b1;
            end
          end
          if (scan_done) begin
            state_r <= ST_LOAD;
          end
        end
        default: begin
          state_r <= ST_LOAD;
          iss_r   <= 1'b0;
        end
      endcase
    end
  end

  // A last beat that finds the store full is dropped too; remember that for the result.
  logic last_dropped_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dropped_r <= 1'b0;
    end else if (accept && in_last_day) begin
      last_dropped_r <= !has_room;
    end
  end

  assign scan_ctrl.clear     = accept && in_last_day;
  assign scan_ctrl.data_vld  = data_vld_r;
  assign scan_ctrl.data_last = data_last_r;

  ttmr_day_ram #(
    .DEPTH (MAX_DAYS),
    .AW    (AW),
    .DW    (2 * PRICE_BITS)
  ) u_day_ram (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({best_nxt, in_price}),
    .rd_en   (iss_r),
    .rd_addr (ptr_r),
    .rd_data (rd_data)
  );

  ttmr_scan #(
    .PRICE_BITS (PRICE_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (scan_ctrl),
    .rd_data (rd_data),
    .total_r (out_best_total),
    .done_r  (scan_done)
  );

  // The result beat lives for the single cycle in which the scan reports completion.
  assign out_valid   = scan_done;
  assign out_dropped = overflow_r || last_dropped_r;

endmodule

`default_nettype wire

// ===== hdl/ttmr_day_ram.sv =====
// Day store: one synchronous memory holding each day's price and prefix best rise.
// One write port and one read port, read data registered.
// Depends on nothing.
`default_nettype none

module ttmr_day_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ttmr_scan.sv =====
// Backward scan datapath: tracks the suffix maximum and best suffix rise, then the best total.
// Two stages: suffix update, then prefix-plus-suffix sum and maximum.
// Depends on ttmr_pkg.
`default_nettype none

module ttmr_scan #(
  parameter int PRICE_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ttmr_pkg::ttmr_scan_ctrl_t   ctrl,
  input  wire logic [2*PRICE_BITS-1:0]     rd_data,
  output logic      [PRICE_BITS:0]         total_r,
  output logic                             done_r
);

  import ttmr_pkg::*;

  logic [PRICE_BITS-1:0] price;
  logic [PRICE_BITS-1:0] prefix;
  logic [PRICE_BITS-1:0] high_r;
  logic [PRICE_BITS-1:0] sfx_r;
  logic [PRICE_BITS-1:0] pre_a_r;
  logic [PRICE_BITS-1:0] drop;
  logic                  va_r;
  logic                  la_r;
  logic [PRICE_BITS:0]   sum;

  assign price  = rd_data[PRICE_BITS-1:0];
  assign prefix = rd_data[2*PRICE_BITS-1:PRICE_BITS];
  assign drop   = high_r - price;
  assign sum    = {1'b0, pre_a_r} + {1'b0, sfx_r};

  // Stage A: suffix maximum and best suffix rise.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      high_r <= '0;
      sfx_r  <= '0;
    end else if (ctrl.data_vld) begin
      if (price > high_r) begin
        high_r <= price;
      end else if (drop > sfx_r) begin
        sfx_r <= drop;
      end
    end
    if (ctrl.data_vld) begin
      pre_a_r <= prefix;
    end
  end

  // Stage B: best combined total.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      total_r <= '0;
    end else if (va_r && (sum > total_r)) begin
      total_r <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      la_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      va_r   <= ctrl.data_vld;
      la_r   <= ctrl.data_vld && ctrl.data_last;
      done_r <= la_r;
    end
  end

endmodule

`default_nettype wire
